FILE: design/mfis_pkg.sv
package mfis_pkg;

	// input action codes
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_HEADER = 2'd1;
	localparam logic [1:0] ACT_VERTEX = 2'd2;
	localparam logic [1:0] ACT_HOLE   = 2'd3;

	// result kind codes
	localparam logic [1:0] KIND_INDEX   = 2'd0;
	localparam logic [1:0] KIND_VERDICT = 2'd1;
	localparam logic [1:0] KIND_HOLE    = 2'd2;

	// configuration register indexes
	localparam logic CFG_VERTEX_LIMIT = 1'b0;
	localparam logic CFG_INDEX_TOTAL  = 1'b1;

	// fixed field widths
	localparam int FACE_W  = 12;
	localparam int DROP_W  = 16;
	localparam int SIZE_W  = 16;
	localparam int VALUE_W = 32;

	// controller to datapath
	typedef struct packed {
		logic capture;       // latch the accepted item
		logic clear;         // start a new mesh
		logic vertex;        // apply a vertex item to the open face
		logic invalidate;    // abandon the open face
		logic header;        // apply a face header
		logic hole_rd;       // look up the remap table
		logic buf_rd_first;  // fetch the first buffered index
		logic emit_index;    // load a kept index into the output register
		logic emit_verdict;  // load the verdict and retire the face
		logic emit_hole;     // load the hole answer
		logic last;          // final result of the item
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] act;
		logic       in_face;
		logic       exp_one;    // one vertex still awaited
		logic       hdr_done;   // header finishes a face at once
		logic       keep_emit;  // face is kept and has indices to send
		logic       emit_more;  // more buffered indices after this one
		logic       out_free;   // output register can take a result
	} stat_t;

endpackage

FILE: design/mesh_face_index_sanitizer_top.sv
// channel   direction  handshake                   payload
// item      in         item_valid / item_ready     action face_size vertex_value hole_face
// result    out        result_valid / result_ready kind kept_index new_face source_face
//                                                  kept dropped_total last
// config    in         cfg_we (no wait)            cfg_index cfg_data
//
// one item at a time: a transfer, then decode. a vertex that does not close its face,
// a clear, a stray vertex or a plain header is then done; a header after an abandoned
// face first runs that face's verdict sequence, and one closing a face runs its own.
// a closed face sends its kept indices one by one through the single read port of the
// face buffer, then its verdict; a hole query reads the remap table before its answer.
// reset clears all control state; the buffer and remap table need no clearing.
// a busy result register holds the controller in place until result_ready.
module mesh_face_index_sanitizer_top #(
	parameter int MAX_FACE_VERTS = 16,
	parameter int MAX_FACES      = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  action,
	input  logic [15:0] face_size,
	input  logic [31:0] vertex_value,
	input  logic [31:0] hole_face,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  kind,
	output logic [31:0] kept_index,
	output logic [11:0] new_face,
	output logic [11:0] source_face,
	output logic        kept,
	output logic [15:0] dropped_total,
	output logic        last
);

	mfis_pkg::cmd_t  cmd;
	mfis_pkg::stat_t stat;

	// sequencer
	mfis_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// storage, checks and result register
	mfis_dp #(
		.MAX_FACE_VERTS (MAX_FACE_VERTS),
		.MAX_FACES      (MAX_FACES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.face_size     (face_size),
		.vertex_value  (vertex_value),
		.hole_face     (hole_face),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.kind          (kind),
		.kept_index    (kept_index),
		.new_face      (new_face),
		.source_face   (source_face),
		.kept          (kept),
		.dropped_total (dropped_total),
		.last          (last)
	);

endmodule

FILE: design/mfis_ctrl.sv
module mfis_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  mfis_pkg::stat_t stat,
	output mfis_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_HDR  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_VERD = 3'd5;
	localparam logic [2:0] ST_HOLE = 3'd6;

	logic [2:0] state_q, state_d;
	logic       abandon_q, abandon_d;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		abandon_d  = abandon_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISP;
				end
			end
			ST_DISP: begin
				case (stat.act)
					mfis_pkg::ACT_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end
					mfis_pkg::ACT_HEADER: begin
						if (stat.in_face) begin
							cmd.invalidate = 1'b1;
							abandon_d      = 1'b1;
							state_d        = ST_FIN;
						end else begin
							cmd.header = 1'b1;
							state_d    = stat.hdr_done ? ST_FIN : ST_IDLE;
						end
					end
					mfis_pkg::ACT_VERTEX: begin
						if (!stat.in_face) begin
							state_d = ST_IDLE;
						end else begin
							cmd.vertex = 1'b1;
							state_d    = stat.exp_one ? ST_FIN : ST_IDLE;
						end
					end
					default: begin
						cmd.hole_rd = 1'b1;
						state_d     = ST_HOLE;
					end
				endcase
			end
			ST_HDR: begin
				cmd.header = 1'b1;
				state_d    = stat.hdr_done ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (stat.keep_emit) begin
					cmd.buf_rd_first = 1'b1;
					state_d          = ST_EMIT;
				end else begin
					state_d = ST_VERD;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_index = 1'b1;
					if (!stat.emit_more)
						state_d = ST_VERD;
				end
			end
			ST_VERD: begin
				if (stat.out_free) begin
					cmd.emit_verdict = 1'b1;
					// an abandoned face is followed by its header, whose own verdict follows if it closes a face
					cmd.last = abandon_q ? !stat.hdr_done : 1'b1;
					if (abandon_q) begin
						abandon_d = 1'b0;
						state_d   = ST_HDR;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_HOLE: begin
				if (stat.out_free) begin
					cmd.emit_hole = 1'b1;
					cmd.last      = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			abandon_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			abandon_q <= abandon_d;
		end
	end

endmodule

FILE: design/mfis_dp.sv
module mfis_dp #(
	parameter int MAX_FACE_VERTS = 16,
	parameter int MAX_FACES      = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mfis_pkg::cmd_t              cmd,
	output mfis_pkg::stat_t             stat,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic [1:0]                  action,
	input  logic [mfis_pkg::SIZE_W-1:0] face_size,
	input  logic [31:0]                 vertex_value,
	input  logic [31:0]                 hole_face,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [1:0]                  kind,
	output logic [31:0]                 kept_index,
	output logic [mfis_pkg::FACE_W-1:0] new_face,
	output logic [mfis_pkg::FACE_W-1:0] source_face,
	output logic                        kept,
	output logic [mfis_pkg::DROP_W-1:0] dropped_total,
	output logic                        last
);

	localparam int FW = $clog2(MAX_FACE_VERTS);
	localparam int NW = $clog2(MAX_FACE_VERTS + 1);
	localparam int AW = $clog2(MAX_FACES);
	localparam int CW = AW + 1;

	// configuration and captured item
	logic [31:0]                 vertex_limit_q, index_total_q;
	logic [1:0]                  act_q;
	logic [mfis_pkg::SIZE_W-1:0] size_q;
	logic [31:0]                 vval_q, hole_q;

	// face and mesh state
	logic [32:0]                 offset_q;
	logic                        overrun_q, in_face_q, face_valid_q;
	logic [mfis_pkg::SIZE_W-1:0] expected_q;
	logic [NW-1:0]               filled_q;
	logic [CW-1:0]               authored_q, kept_q;
	logic [mfis_pkg::DROP_W-1:0] dropped_q;
	logic [FW-1:0]               emit_q;

	// memories and their read data
	logic [31:0]                 face_buf [MAX_FACE_VERTS];
	logic [CW-1:0]               remap_mem [MAX_FACES];
	logic [31:0]                 buf_rd_q;
	logic [CW-1:0]               remap_rd_q;

	logic                        out_valid_q;

	logic [33:0]                 hdr_sum;
	logic                        hdr_overrun, table_full, keep, emit_more, out_free;
	logic                        buf_rd_en, buf_wr_en;
	logic [FW-1:0]               buf_rd_addr;
	logic [mfis_pkg::DROP_W-1:0] dropped_inc;
	logic [31:0]                 kept_nf32, auth_src32, remap_nf32;
	logic                        any_emit;
	logic [1:0]                  kind_d;
	logic [31:0]                 index_d;
	logic [mfis_pkg::FACE_W-1:0] nf_d, src_d;
	logic                        kept_d;
	logic [mfis_pkg::DROP_W-1:0] drop_d;

	// header overrun check against the authored index length
	assign hdr_sum     = 34'(offset_q) + 34'(size_q);
	assign hdr_overrun = overrun_q || (hdr_sum > 34'(index_total_q));

	assign table_full  = (authored_q == CW'(MAX_FACES));
	assign keep        = face_valid_q && !table_full;
	assign emit_more   = ((NW'(emit_q) + NW'(1)) < filled_q);
	assign out_free    = !out_valid_q || result_ready;
	assign dropped_inc = (dropped_q == {mfis_pkg::DROP_W{1'b1}}) ? dropped_q
	                                                              : dropped_q + 1'b1;

	assign stat.act       = act_q;
	assign stat.in_face   = in_face_q;
	assign stat.exp_one   = (expected_q == mfis_pkg::SIZE_W'(1));
	assign stat.hdr_done  = hdr_overrun || (size_q == '0);
	assign stat.keep_emit = keep && (filled_q != '0);
	assign stat.emit_more = emit_more;
	assign stat.out_free  = out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_limit_q <= '0;
			index_total_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mfis_pkg::CFG_VERTEX_LIMIT: vertex_limit_q <= cfg_data;
				mfis_pkg::CFG_INDEX_TOTAL:  index_total_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture on transfer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action;
			size_q <= face_size;
			vval_q <= vertex_value;
			hole_q <= hole_face;
		end
	end

	// face and mesh bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= '0;
			overrun_q    <= 1'b0;
			in_face_q    <= 1'b0;
			face_valid_q <= 1'b1;
			expected_q   <= '0;
			filled_q     <= '0;
			authored_q   <= '0;
			kept_q       <= '0;
			dropped_q    <= '0;
			emit_q       <= '0;
		end else begin
			if (cmd.clear) begin
				offset_q     <= '0;
				overrun_q    <= 1'b0;
				in_face_q    <= 1'b0;
				face_valid_q <= 1'b1;
				expected_q   <= '0;
				filled_q     <= '0;
				authored_q   <= '0;
				kept_q       <= '0;
				dropped_q    <= '0;
			end
			if (cmd.invalidate)
				face_valid_q <= 1'b0;
			if (cmd.header) begin
				filled_q <= '0;
				if (hdr_overrun) begin
					overrun_q    <= 1'b1;
					face_valid_q <= 1'b0;
				end else begin
					offset_q     <= hdr_sum[32:0];
					face_valid_q <= (size_q <= mfis_pkg::SIZE_W'(MAX_FACE_VERTS));
					expected_q   <= size_q;
					in_face_q    <= 1'b1;
				end
			end
			if (cmd.vertex) begin
				if (vval_q >= vertex_limit_q)
					face_valid_q <= 1'b0;
				if (buf_wr_en)
					filled_q <= filled_q + 1'b1;
				expected_q <= expected_q - 1'b1;
			end
			if (cmd.buf_rd_first)
				emit_q <= '0;
			if (cmd.emit_index && emit_more)
				emit_q <= emit_q + 1'b1;
			// retire the face
			if (cmd.emit_verdict) begin
				if (keep) begin
					if (kept_q < CW'(MAX_FACES))
						kept_q <= kept_q + 1'b1;
				end else begin
					dropped_q <= dropped_inc;
				end
				if (!table_full)
					authored_q <= authored_q + 1'b1;
				in_face_q    <= 1'b0;
				face_valid_q <= 1'b1;
				expected_q   <= '0;
				filled_q     <= '0;
			end
		end
	end

	// face buffer
	assign buf_wr_en   = cmd.vertex && (filled_q < NW'(MAX_FACE_VERTS));
	assign buf_rd_en   = cmd.buf_rd_first || (cmd.emit_index && emit_more);
	assign buf_rd_addr = cmd.buf_rd_first ? '0 : emit_q + 1'b1;

	always_ff @(posedge clk) begin
		if (buf_wr_en)
			face_buf[filled_q[FW-1:0]] <= vval_q;
		if (buf_rd_en)
			buf_rd_q <= face_buf[buf_rd_addr];
	end

	// remap table: new face number plus one, zero for a dropped face
	always_ff @(posedge clk) begin
		if (cmd.emit_verdict && !table_full)
			remap_mem[authored_q[AW-1:0]] <= keep ? kept_q + 1'b1 : '0;
		if (cmd.hole_rd)
			remap_rd_q <= remap_mem[hole_q[AW-1:0]];
	end

	// result selection
	assign kept_nf32  = 32'(kept_q);
	assign auth_src32 = 32'(authored_q);
	assign remap_nf32 = 32'(remap_rd_q - 1'b1);
	assign any_emit   = cmd.emit_index || cmd.emit_verdict || cmd.emit_hole;

	always_comb begin
		kind_d  = mfis_pkg::KIND_INDEX;
		index_d = '0;
		nf_d    = kept_nf32[mfis_pkg::FACE_W-1:0];
		src_d   = auth_src32[mfis_pkg::FACE_W-1:0];
		kept_d  = 1'b1;
		drop_d  = dropped_q;
		if (cmd.emit_index) begin
			index_d = buf_rd_q;
		end else if (cmd.emit_verdict) begin
			kind_d = mfis_pkg::KIND_VERDICT;
			kept_d = keep;
			if (!keep) begin
				nf_d   = '0;
				drop_d = dropped_inc;
			end
		end else begin
			kind_d = mfis_pkg::KIND_HOLE;
			src_d  = hole_q[mfis_pkg::FACE_W-1:0];
			if (dropped_q == '0) begin
				nf_d = hole_q[mfis_pkg::FACE_W-1:0];
			end else if ((hole_q < 32'(authored_q)) && (remap_rd_q != '0)) begin
				nf_d = remap_nf32[mfis_pkg::FACE_W-1:0];
			end else begin
				nf_d   = '0;
				kept_d = 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (any_emit)
			out_valid_q <= 1'b1;
		else if (result_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (any_emit) begin
			kind          <= kind_d;
			kept_index    <= index_d;
			new_face      <= nf_d;
			source_face   <= src_d;
			kept          <= kept_d;
			dropped_total <= drop_d;
			last          <= cmd.last;
		end
	end

	assign result_valid = out_valid_q;

	// checks
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		any_emit |-> out_free)
		else $error("result loaded while output register is busy");
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_index, cmd.emit_verdict, cmd.emit_hole}))
		else $error("two results loaded in one cycle");
	a_open_face: assert property (@(posedge clk) disable iff (!arst_n)
		!in_face_q |-> (expected_q == '0))
		else $error("vertices awaited with no open face");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= NW'(MAX_FACE_VERTS))
		else $error("face buffer overfilled");
	a_vertex_open: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.vertex |-> in_face_q)
		else $error("vertex applied outside a face");

endmodule
